// File: sv/tmcs_pkg.sv
// Shared types and constants for the text mode cell screen.
// Holds command and cell layouts, request and register codes.
// No dependencies.
`default_nettype none

package tmcs_pkg;

  localparam int CP_W      = 21;
  localparam int COLOR_W   = 32;
  localparam int POS_W     = 16;
  localparam int GRID_W    = 7;
  localparam int CUR_OUT_W = 6;

  // magnitude of a column or carried row value, and the carried row sum
  localparam int DIV_W = 17;
  localparam int YY_W  = 18;

  localparam logic [CP_W-1:0]    SPACE_CODE   = 21'd32;
  localparam logic [CP_W-1:0]    NEWLINE_CODE = 21'd10;
  localparam logic [COLOR_W-1:0] INK_RESET    = 32'd8;
  localparam logic [COLOR_W-1:0] PAPER_RESET  = 32'd0;
  localparam logic [GRID_W-1:0]  COLS_RESET   = 7'd32;
  localparam logic [GRID_W-1:0]  ROWS_RESET   = 7'd18;
  localparam int                 CURSOR_Y_RESET = 17;

  localparam logic [1:0] REQ_PRINT = 2'd0;
  localparam logic [1:0] REQ_SET   = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;
  localparam logic [1:0] REQ_READ  = 2'd3;

  localparam logic [1:0] CFG_INK   = 2'd0;
  localparam logic [1:0] CFG_PAPER = 2'd1;
  localparam logic [1:0] CFG_COLS  = 2'd2;
  localparam logic [1:0] CFG_ROWS  = 2'd3;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    OP_PRINT,
    OP_NEWLINE,
    OP_NOP,
    OP_SET,
    OP_CLEAR,
    OP_READ,
    OP_MISS
  } tmcs_op_t;

  typedef struct packed {
    tmcs_op_t                 op;
    logic [CP_W-1:0]          codepoint;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
  } tmcs_cmd_t;

  typedef struct packed {
    logic [CP_W-1:0]    codepoint;
    logic [COLOR_W-1:0] ink;
    logic [COLOR_W-1:0] paper;
  } tmcs_cell_t;

endpackage

`default_nettype wire

// File: sv/tmcs_front.sv
// Front end: accepts request words and classifies them into commands.
// Depends on tmcs_pkg; feeds tmcs_queue.
`default_nettype none

module tmcs_front import tmcs_pkg::*; #(
  parameter int MAX_COLUMNS = 64,
  parameter int MAX_ROWS    = 64
) (
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [1:0]                          req_type,
  input  wire logic [CP_W-1:0]                     codepoint,
  input  wire logic signed [POS_W-1:0]             pos_x,
  input  wire logic signed [POS_W-1:0]             pos_y,
  input  wire logic                                q_full,
  input  wire logic                                init_busy,
  input  wire logic [$clog2(MAX_COLUMNS+1)-1:0]    cols_eff,
  input  wire logic [$clog2(MAX_ROWS+1)-1:0]       rows_eff,
  output logic                                     push,
  output tmcs_cmd_t                                push_cmd
);

  logic hit;

  assign in_stall = q_full || init_busy;
  assign push     = in_valid && !in_stall;

  assign hit = !pos_x[POS_W-1] && !pos_y[POS_W-1] &&
               ($unsigned(pos_x) < POS_W'(cols_eff)) &&
               ($unsigned(pos_y) < POS_W'(rows_eff));

  always_comb begin
    push_cmd.codepoint = codepoint;
    push_cmd.pos_x     = pos_x;
    push_cmd.pos_y     = pos_y;
    unique case (req_type)
      REQ_PRINT: begin
        if (codepoint == '0) begin
          push_cmd.op = OP_NOP;
        end else if (codepoint == NEWLINE_CODE) begin
          push_cmd.op = OP_NEWLINE;
        end else begin
          push_cmd.op = OP_PRINT;
        end
      end
      REQ_SET:   push_cmd.op = OP_SET;
      REQ_CLEAR: push_cmd.op = OP_CLEAR;
      REQ_READ:  push_cmd.op = hit ? OP_READ : OP_MISS;
    endcase
  end

endmodule

`default_nettype wire

// File: sv/tmcs_queue.sv
// Short command queue between the front end and the back end.
// Depends on tmcs_pkg for the command layout and depth.
`default_nettype none

module tmcs_queue import tmcs_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  wire tmcs_cmd_t push_cmd,
  output logic           full,
  input  wire logic      pop,
  output logic           q_valid,
  output tmcs_cmd_t      q_cmd
);

  localparam int PW = (QUEUE_PW > 0) ? QUEUE_PW : 1;

  tmcs_cmd_t             entries [QUEUE_DEPTH];
  logic [PW-1:0]         wptr;
  logic [PW-1:0]         rptr;
  logic [QUEUE_CW-1:0]   count;

  assign full    = (count == QUEUE_CW'(QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign q_cmd   = entries[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/tmcs_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Self-contained; used by tmcs_back for cursor placement.
`default_nettype none

module tmcs_div #(
  parameter int N = 17,
  parameter int M = 7
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [N-1:0]  dividend,
  input  wire logic [M-1:0]  divisor,
  output logic               busy,
  output logic [N-1:0]       quot,
  output logic [M-1:0]       rem
);

  localparam int KW = (N > 1) ? $clog2(N) : 1;

  logic [M-1:0]  dsr;
  logic [KW-1:0] step;
  logic [M:0]    trial;
  logic          take;

  assign trial = {rem, quot[N-1]};
  assign take  = (trial >= {1'b0, dsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= '0;
      quot <= dividend;
      rem  <= '0;
      dsr  <= divisor;
    end else if (busy) begin
      // shift in one dividend bit, subtract where it fits
      rem  <= take ? M'(trial - {1'b0, dsr}) : M'(trial);
      quot <= {quot[N-2:0], take};
      step <= step + 1'b1;
      if (step == KW'(N - 1)) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/tmcs_back.sv
// Back end: cell memory, cursor, clear sweep, cursor divide and result register.
// Depends on tmcs_pkg and tmcs_div; fed by tmcs_queue.
`default_nettype none

module tmcs_back import tmcs_pkg::*; #(
  parameter int MAX_COLUMNS = 64,
  parameter int MAX_ROWS    = 64
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                q_valid,
  input  wire tmcs_cmd_t                           q_cmd,
  output logic                                     q_pop,
  input  wire logic [$clog2(MAX_COLUMNS+1)-1:0]    cols_eff,
  input  wire logic [$clog2(MAX_ROWS+1)-1:0]       rows_eff,
  input  wire logic [COLOR_W-1:0]                  ink_color,
  input  wire logic [COLOR_W-1:0]                  paper_color,
  output logic                                     init_busy,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic                                     in_range,
  output logic [CP_W-1:0]                          cell_codepoint,
  output logic [COLOR_W-1:0]                       cell_ink,
  output logic [COLOR_W-1:0]                       cell_paper,
  output logic [CUR_OUT_W-1:0]                     cursor_col,
  output logic [CUR_OUT_W-1:0]                     cursor_row
);

  localparam int XW    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int YW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW    = $clog2(MAX_COLUMNS + 1);
  localparam int RW    = $clog2(MAX_ROWS + 1);
  localparam int DVW   = (CW > RW) ? CW : RW;
  localparam int CELLS = MAX_COLUMNS * MAX_ROWS;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int PRW   = YW + CW + 1;
  localparam logic [AW-1:0] FILL_LAST = AW'(CELLS - 1);

  typedef enum logic [2:0] {
    S_FILL,
    S_IDLE,
    S_READ,
    S_DIVX,
    S_YSTART,
    S_DIVY
  } state_t;

  state_t           state;
  logic             fill_report;
  logic [AW-1:0]    fill_addr;
  logic [XW-1:0]    cursor_x;
  logic [YW-1:0]    cursor_y;
  logic [XW-1:0]    set_x;
  logic             px_neg;
  logic signed [POS_W-1:0] hold_py;
  logic signed [YY_W-1:0]  yy;

  tmcs_cell_t       mem [CELLS];
  tmcs_cell_t       rd_data;
  tmcs_cell_t       wr_data;
  logic             wr_en;
  logic             rd_en;
  logic [AW-1:0]    wr_addr;

  logic             out_free;
  logic             print_pop;
  logic [YW-1:0]    mul_y;
  logic [XW-1:0]    mul_x;
  logic [PRW-1:0]   prod;
  logic [AW-1:0]    cell_addr;

  logic [CW:0]      x_inc;
  logic             x_wrap;
  logic [XW-1:0]    x_next;
  logic [YW-1:0]    y_next;

  logic             div_start;
  logic [DIV_W-1:0] div_dividend;
  logic [DVW-1:0]   div_divisor;
  logic             div_busy;
  logic [DIV_W-1:0] div_quot;
  logic [DVW-1:0]   div_rem;
  logic             rem_nz;

  logic [DIV_W:0]          px_ext;
  logic [DIV_W-1:0]        px_mag;
  logic signed [YY_W-1:0]  q_ext;
  logic signed [YY_W-1:0]  carry;
  logic [XW-1:0]           sx_val;
  logic signed [YY_W-1:0]  yy_val;
  logic [YY_W-1:0]         yy_negv;
  logic [DIV_W-1:0]        yy_mag;
  logic [YW-1:0]           sy_val;

  assign init_busy = (state == S_FILL) && !fill_report;
  assign out_free  = !out_valid || !out_stall;

  always_comb begin
    q_pop = 1'b0;
    if (state == S_IDLE && q_valid) begin
      unique case (q_cmd.op)
        OP_READ, OP_SET, OP_CLEAR:         q_pop = 1'b1;
        OP_PRINT, OP_NEWLINE, OP_NOP, OP_MISS: q_pop = out_free;
        default:                           q_pop = 1'b0;
      endcase
    end
  end

  assign print_pop = q_pop && (q_cmd.op == OP_PRINT || q_cmd.op == OP_NEWLINE);

  // one shared row-major address multiplier for reads and prints
  always_comb begin
    if (q_cmd.op == OP_READ) begin
      mul_y = q_cmd.pos_y[YW-1:0];
      mul_x = q_cmd.pos_x[XW-1:0];
    end else begin
      mul_y = cursor_y;
      mul_x = cursor_x;
    end
  end

  assign prod      = PRW'(mul_y) * PRW'(cols_eff) + PRW'(mul_x);
  assign cell_addr = prod[AW-1:0];

  // cursor advance after a print; a newline always wraps
  assign x_inc  = (CW + 1)'(cursor_x) + 1'b1;
  assign x_wrap = (q_cmd.op == OP_NEWLINE) || (x_inc >= (CW + 1)'(cols_eff));
  assign x_next = x_wrap ? '0 : XW'(x_inc);

  always_comb begin
    if (!x_wrap) begin
      y_next = cursor_y;
    end else if (cursor_y == '0) begin
      y_next = YW'(rows_eff - 1'b1);
    end else begin
      y_next = cursor_y - 1'b1;
    end
  end

  // column reduction: floor division of the signed column by the width
  assign px_ext = {q_cmd.pos_x[POS_W-1], q_cmd.pos_x[POS_W-1], q_cmd.pos_x};
  assign px_mag = q_cmd.pos_x[POS_W-1] ? DIV_W'((DIV_W + 1)'(0) - px_ext)
                                       : DIV_W'(px_ext);
  assign rem_nz = (div_rem != '0);
  assign q_ext  = YY_W'(div_quot);
  assign carry  = px_neg ? (YY_W'(0) - q_ext - YY_W'(rem_nz)) : q_ext;
  assign sx_val = (px_neg && rem_nz) ? XW'(DVW'(cols_eff) - div_rem) : XW'(div_rem);
  assign yy_val = {{(YY_W - POS_W){hold_py[POS_W-1]}}, hold_py} + carry;

  // row reduction of the carried row sum
  assign yy_negv = YY_W'(0) - yy;
  assign yy_mag  = yy[YY_W-1] ? yy_negv[DIV_W-1:0] : yy[DIV_W-1:0];
  assign sy_val  = (yy[YY_W-1] && rem_nz) ? YW'(DVW'(rows_eff) - div_rem)
                                         : YW'(div_rem);

  assign div_start    = (q_pop && q_cmd.op == OP_SET) || (state == S_YSTART);
  assign div_dividend = (state == S_YSTART) ? yy_mag : px_mag;
  assign div_divisor  = (state == S_YSTART) ? DVW'(rows_eff) : DVW'(cols_eff);

  tmcs_div #(
    .N (DIV_W),
    .M (DVW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // cell memory: one write and one registered read per cycle
  assign wr_en   = (state == S_FILL) || print_pop;
  assign wr_addr = (state == S_FILL) ? fill_addr : cell_addr;
  assign rd_en   = q_pop && (q_cmd.op == OP_READ);

  always_comb begin
    if (state == S_FILL) begin
      wr_data.codepoint = SPACE_CODE;
      wr_data.ink       = fill_report ? ink_color : INK_RESET;
      wr_data.paper     = fill_report ? paper_color : PAPER_RESET;
    end else begin
      wr_data.codepoint = q_cmd.codepoint;
      wr_data.ink       = ink_color;
      wr_data.paper     = paper_color;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[cell_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_FILL;
      fill_report <= 1'b0;
      fill_addr   <= '0;
      out_valid   <= 1'b0;
      cursor_x    <= '0;
      cursor_y    <= YW'(CURSOR_Y_RESET);
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_FILL: begin
          if (fill_addr != FILL_LAST) begin
            fill_addr <= fill_addr + 1'b1;
          end else if (!fill_report) begin
            state <= S_IDLE;
          end else if (out_free) begin
            out_valid      <= 1'b1;
            in_range       <= 1'b0;
            cell_codepoint <= '0;
            cell_ink       <= '0;
            cell_paper     <= '0;
            cursor_col     <= CUR_OUT_W'(cursor_x);
            cursor_row     <= CUR_OUT_W'(cursor_y);
            state          <= S_IDLE;
          end
        end
        S_IDLE: begin
          // pull the cursor back into a grid that shrank under it
          if (cursor_x >= cols_eff) begin
            cursor_x <= XW'(cols_eff - 1'b1);
          end
          if (cursor_y >= rows_eff) begin
            cursor_y <= YW'(rows_eff - 1'b1);
          end
          if (q_pop) begin
            unique case (q_cmd.op)
              OP_PRINT, OP_NEWLINE: begin
                cursor_x       <= x_next;
                cursor_y       <= y_next;
                out_valid      <= 1'b1;
                in_range       <= 1'b0;
                cell_codepoint <= '0;
                cell_ink       <= '0;
                cell_paper     <= '0;
                cursor_col     <= CUR_OUT_W'(x_next);
                cursor_row     <= CUR_OUT_W'(y_next);
              end
              OP_NOP, OP_MISS: begin
                out_valid      <= 1'b1;
                in_range       <= 1'b0;
                cell_codepoint <= '0;
                cell_ink       <= '0;
                cell_paper     <= '0;
                cursor_col     <= CUR_OUT_W'(cursor_x);
                cursor_row     <= CUR_OUT_W'(cursor_y);
              end
              OP_READ: begin
                state <= S_READ;
              end
              OP_SET: begin
                px_neg  <= q_cmd.pos_x[POS_W-1];
                hold_py <= q_cmd.pos_y;
                state   <= S_DIVX;
              end
              OP_CLEAR: begin
                fill_report <= 1'b1;
                fill_addr   <= '0;
                state       <= S_FILL;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_READ: begin
          if (out_free) begin
            out_valid      <= 1'b1;
            in_range       <= 1'b1;
            cell_codepoint <= rd_data.codepoint;
            cell_ink       <= rd_data.ink;
            cell_paper     <= rd_data.paper;
            cursor_col     <= CUR_OUT_W'(cursor_x);
            cursor_row     <= CUR_OUT_W'(cursor_y);
            state          <= S_IDLE;
          end
        end
        S_DIVX: begin
          if (!div_busy) begin
            set_x <= sx_val;
            yy    <= yy_val;
            state <= S_YSTART;
          end
        end
        S_YSTART: begin
          state <= S_DIVY;
        end
        S_DIVY: begin
          if (!div_busy && out_free) begin
            cursor_x       <= set_x;
            cursor_y       <= sy_val;
            out_valid      <= 1'b1;
            in_range       <= 1'b0;
            cell_codepoint <= '0;
            cell_ink       <= '0;
            cell_paper     <= '0;
            cursor_col     <= CUR_OUT_W'(set_x);
            cursor_row     <= CUR_OUT_W'(sy_val);
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_no_result_in_init: assert property (@(posedge clk) disable iff (rst)
    init_busy |-> !out_valid)
    else $error("result presented during the power-up fill");

  a_cursor_in_grid: assert property (@(posedge clk) disable iff (rst)
    print_pop |=> (cursor_x < cols_eff) && (cursor_y < rows_eff))
    else $error("cursor left the grid after a print");

  a_row_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIVY && !div_busy) |-> (div_rem < DVW'(rows_eff)))
    else $error("row remainder not below the row count");

endmodule

`default_nettype wire

// File: sv/text_mode_cell_screen_unit.sv
// Text mode cell screen: top level with configuration registers.
// Prints, empty prints and missed reads pass the queue and the result register,
// one per cycle while out_stall is low; a cell read adds the memory read register.
// Set cursor: two 17-step divider passes, column then row, via S_DIVX, S_YSTART, S_DIVY.
// Clear sweeps MAX_COLUMNS*MAX_ROWS cells, one cell written per cycle.
// Reset: a fill sweep of MAX_COLUMNS*MAX_ROWS cells (4096 by default) holds in_stall.
`default_nettype none

module text_mode_cell_screen_unit import tmcs_pkg::*; #(
  parameter int MAX_COLUMNS = 64,
  parameter int MAX_ROWS    = 64
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cfg_we,
  input  wire logic [1:0]              cfg_index,
  input  wire logic [COLOR_W-1:0]      cfg_data,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic [1:0]              req_type,
  input  wire logic [CP_W-1:0]         codepoint,
  input  wire logic signed [POS_W-1:0] pos_x,
  input  wire logic signed [POS_W-1:0] pos_y,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic                         in_range,
  output logic [CP_W-1:0]              cell_codepoint,
  output logic [COLOR_W-1:0]           cell_ink,
  output logic [COLOR_W-1:0]           cell_paper,
  output logic [CUR_OUT_W-1:0]         cursor_col,
  output logic [CUR_OUT_W-1:0]         cursor_row
);

  localparam int CW = $clog2(MAX_COLUMNS + 1);
  localparam int RW = $clog2(MAX_ROWS + 1);

  logic [COLOR_W-1:0] ink_color;
  logic [COLOR_W-1:0] paper_color;
  logic [GRID_W-1:0]  columns;
  logic [GRID_W-1:0]  rows;
  logic [CW-1:0]      cols_eff;
  logic [RW-1:0]      rows_eff;

  logic       push;
  tmcs_cmd_t  push_cmd;
  logic       q_full;
  logic       q_pop;
  logic       q_valid;
  tmcs_cmd_t  q_cmd;
  logic       init_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      ink_color   <= INK_RESET;
      paper_color <= PAPER_RESET;
      columns     <= COLS_RESET;
      rows        <= ROWS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_INK:   ink_color   <= cfg_data;
        CFG_PAPER: paper_color <= cfg_data;
        CFG_COLS:  columns     <= cfg_data[GRID_W-1:0];
        CFG_ROWS:  rows        <= cfg_data[GRID_W-1:0];
      endcase
    end
  end

  // zero acts as one, anything past the store acts as the store size
  always_comb begin
    if (columns == '0) begin
      cols_eff = CW'(1);
    end else if (int'(columns) > MAX_COLUMNS) begin
      cols_eff = CW'(MAX_COLUMNS);
    end else begin
      cols_eff = CW'(columns);
    end
    if (rows == '0) begin
      rows_eff = RW'(1);
    end else if (int'(rows) > MAX_ROWS) begin
      rows_eff = RW'(MAX_ROWS);
    end else begin
      rows_eff = RW'(rows);
    end
  end

  tmcs_front #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_front (
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .req_type  (req_type),
    .codepoint (codepoint),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .q_full    (q_full),
    .init_busy (init_busy),
    .cols_eff  (cols_eff),
    .rows_eff  (rows_eff),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  tmcs_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd)
  );

  tmcs_back #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .q_cmd          (q_cmd),
    .q_pop          (q_pop),
    .cols_eff       (cols_eff),
    .rows_eff       (rows_eff),
    .ink_color      (ink_color),
    .paper_color    (paper_color),
    .init_busy      (init_busy),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .in_range       (in_range),
    .cell_codepoint (cell_codepoint),
    .cell_ink       (cell_ink),
    .cell_paper     (cell_paper),
    .cursor_col     (cursor_col),
    .cursor_row     (cursor_row)
  );

endmodule

`default_nettype wire
